>>> rtl/assert_macros.svh
// shared assertion macros, clocked on i_clk and quiet while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define RAU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// condition never occurs outside reset
`define RAU_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// constants, codes and operand helpers of the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int WIDTH = 32;  // operand and result width, 8..32

    // largest magnitude bound 2^(WIDTH-1)
    localparam logic [63:0] LIM = 64'd1 << (WIDTH - 1);

    localparam logic [2:0] ACT_ADD  = 3'd0;
    localparam logic [2:0] ACT_SUB  = 3'd1;
    localparam logic [2:0] ACT_MUL  = 3'd2;
    localparam logic [2:0] ACT_DIV  = 3'd3;
    localparam logic [2:0] ACT_CMP  = 3'd4;
    localparam logic [2:0] ACT_NORM = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZDEN = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;
    localparam logic [1:0] ST_OVF  = 2'd3;

    localparam logic [1:0] ORD_LT = 2'd0;
    localparam logic [1:0] ORD_EQ = 2'd1;
    localparam logic [1:0] ORD_GT = 2'd2;

    // magnitude of the low WIDTH bits taken as a signed value
    function automatic logic [31:0] op_mag(input logic [31:0] v);
        logic [32:0] e;
        e = {{(33 - WIDTH){v[WIDTH-1]}}, v[WIDTH-1:0]};
        if (e[32]) begin
            e = -e;
        end
        return e[31:0];
    endfunction

    function automatic logic op_neg(input logic [31:0] v);
        return v[WIDTH-1];
    endfunction

    function automatic logic op_zero(input logic [31:0] v);
        return v[WIDTH-1:0] == '0;
    endfunction

endpackage

>>> rtl/rau_gcd.sv
// ----------------------------------------------------------------------------
// rau_gcd
// binary gcd of two 64-bit magnitudes, one shift or subtract per cycle
// ----------------------------------------------------------------------------
module rau_gcd import rau_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_x,
    input  logic [63:0] i_y,
    output logic        o_done,
    output logic [63:0] o_g
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [63:0] r_u, n_u;
    logic [63:0] r_v, n_v;
    logic [5:0]  r_k, n_k;
    logic [63:0] r_g, n_g;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_u    = r_u;
        n_v    = r_v;
        n_k    = r_k;
        n_g    = r_g;
        if (i_start) begin
            n_busy = 1'b1;
            n_u    = i_x;
            n_v    = i_y;
            n_k    = '0;
        end else if (r_busy) begin
            if (r_u == '0) begin
                n_g    = r_v << r_k;
                n_done = 1'b1;
                n_busy = 1'b0;
            end else if (r_v == '0) begin
                n_g    = r_u << r_k;
                n_done = 1'b1;
                n_busy = 1'b0;
            end else if (!r_u[0] && !r_v[0]) begin
                n_u = r_u >> 1;
                n_v = r_v >> 1;
                n_k = r_k + 6'd1;
            end else if (!r_u[0]) begin
                n_u = r_u >> 1;
            end else if (!r_v[0]) begin
                n_v = r_v >> 1;
            end else if (r_u >= r_v) begin
                n_u = (r_u - r_v) >> 1;
            end else begin
                n_v = (r_v - r_u) >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_u <= n_u;
        r_v <= n_v;
        r_k <= n_k;
        r_g <= n_g;
    end

    assign o_done = r_done;
    assign o_g    = r_g;

endmodule

>>> rtl/rau_div.sv
// ----------------------------------------------------------------------------
// rau_div
// 64-bit restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rau_div import rau_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [5:0]  r_cnt, n_cnt;
    logic [63:0] r_rem, n_rem;
    logic [63:0] r_quo, n_quo;
    logic [63:0] r_den, n_den;
    logic [64:0] w_sh;
    logic        w_ge;

    assign w_sh = {r_rem, r_quo[63]};
    assign w_ge = w_sh >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_num;
            n_den  = i_den;
        end else if (r_busy) begin
            n_rem = w_ge ? 64'(w_sh - {1'b0, r_den}) : w_sh[63:0];
            n_quo = {r_quo[62:0], w_ge};
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd63) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

>>> rtl/rau_mul.sv
// ----------------------------------------------------------------------------
// rau_mul
// 32 by 32 unsigned multiplier with registered product
// ----------------------------------------------------------------------------
module rau_mul import rau_pkg::*; (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_prod
);

    logic [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= {32'd0, i_a} * {32'd0, i_b};
    end

    assign o_prod = r_prod;

endmodule

>>> rtl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// add, subtract, multiply, divide or compare two signed fractions, or normalize the first of the fractions
// ----------------------------------------------------------------------------
// One request at a time. Each operand is reduced by its gcd, then the action
// runs through one shared binary gcd unit, one shared 64-bit bit-serial
// divider and one registered 32x32 multiplier under a small sequencer. A
// reduction runs a gcd, divides the magnitude and then the denominator by
// it and stores the result. The gcd does one shift or subtract per cycle.
// Normalize takes one reduction, compare two, multiply and divide three, add
// and subtract four. Every multiply passes through the S_MUL and S_MUL_WB
// states. Requests with a zero denominator or a division by zero go from
// idle straight to the done state. o_in_stall is low only while the
// sequencer is idle; a finished result sits in the output register until
// taken, and the next request may be accepted while it waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rational_arithmetic_unit import rau_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_action,
    input  logic signed [31:0] i_a_num,
    input  logic signed [31:0] i_a_den,
    input  logic signed [31:0] i_b_num,
    input  logic signed [31:0] i_b_den,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_res_num,
    output logic [30:0]        o_res_den,
    output logic [1:0]         o_order,
    output logic [1:0]         o_status
);

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_GCD_GO   = 4'd1;
    localparam logic [3:0] S_GCD_WAIT = 4'd2;
    localparam logic [3:0] S_DIVX_GO  = 4'd3;
    localparam logic [3:0] S_DIVX_WT  = 4'd4;
    localparam logic [3:0] S_DIVY_GO  = 4'd5;
    localparam logic [3:0] S_DIVY_WT  = 4'd6;
    localparam logic [3:0] S_POST     = 4'd7;
    localparam logic [3:0] S_MUL      = 4'd8;
    localparam logic [3:0] S_MUL_WB   = 4'd9;
    localparam logic [3:0] S_COMB     = 4'd10;
    localparam logic [3:0] S_CMP      = 4'd11;
    localparam logic [3:0] S_CHECK    = 4'd12;
    localparam logic [3:0] S_DONE     = 4'd13;

    // which reduction is running
    localparam logic [1:0] PH_A   = 2'd0;
    localparam logic [1:0] PH_B   = 2'd1;
    localparam logic [1:0] PH_LCM = 2'd2;
    localparam logic [1:0] PH_FIN = 2'd3;

    logic [3:0]  r_state;
    logic [1:0]  r_phase;
    logic [2:0]  r_act;
    logic [1:0]  r_mi;
    // working fraction, reduced in place: r_x magnitude, r_y denominator
    logic [63:0] r_x, r_y, r_g;
    logic        r_neg;
    // reduced operands
    logic [31:0] r_a_mag, r_a_den, r_b_mag, r_b_den;
    logic        r_a_neg, r_b_neg;
    // raw second operand, held until its reduction
    logic [31:0] r_bn_mag, r_bd_mag;
    logic        r_b_sgn;
    // products
    logic [63:0] r_p0, r_p1, r_p2;
    // result being built
    logic signed [31:0] r_rnum;
    logic [30:0] r_rden;
    logic [1:0]  r_ord, r_st;
    // output register
    logic               r_ovalid;
    logic signed [31:0] r_onum;
    logic [30:0]        r_oden;
    logic [1:0]         r_oord, r_ost;

    logic        w_in_acc, w_out_free;
    logic [2:0]  w_act;
    logic        w_gcd_go, w_gcd_done;
    logic [63:0] w_gcd_g;
    logic        w_div_go, w_div_done;
    logic [63:0] w_div_num, w_quo;
    logic [31:0] w_ma, w_mb;
    logic [63:0] w_prod;
    logic        w_last_mul;
    logic        w_bneg;
    logic        w_fits;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_ovalid || !i_out_stall;
    assign w_act      = (i_action > ACT_NORM) ? ACT_NORM : i_action;

    assign w_gcd_go  = r_state == S_GCD_GO;
    assign w_div_go  = (r_state == S_DIVX_GO) || (r_state == S_DIVY_GO);
    assign w_div_num = (r_state == S_DIVX_GO) ? r_x : r_y;

    rau_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_gcd_go),
        .i_x     (r_x),
        .i_y     (r_y),
        .o_done  (w_gcd_done),
        .o_g     (w_gcd_g)
    );

    rau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_go),
        .i_num   (w_div_num),
        .i_den   (r_g),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    rau_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_ma),
        .i_b    (w_mb),
        .o_prod (w_prod)
    );

    // multiplier operand schedule; for add and subtract r_x and r_y hold
    // a.den/g and b.den/g after the lcm reduction
    always_comb begin
        w_ma = r_a_mag;
        w_mb = r_b_den;
        case (r_act) inside
            ACT_ADD, ACT_SUB: begin
                case (r_mi)
                    2'd0:    begin w_ma = r_x[31:0]; w_mb = r_b_den;   end // lcm
                    2'd1:    begin w_ma = r_a_mag;   w_mb = r_y[31:0]; end // scaled a
                    default: begin w_ma = r_b_mag;   w_mb = r_x[31:0]; end // scaled b
                endcase
            end
            ACT_MUL: begin
                w_ma = (r_mi == 2'd0) ? r_a_mag : r_a_den;
                w_mb = (r_mi == 2'd0) ? r_b_mag : r_b_den;
            end
            ACT_DIV: begin
                w_ma = (r_mi == 2'd0) ? r_a_mag : r_a_den;
                w_mb = (r_mi == 2'd0) ? r_b_den : r_b_mag;
            end
            default: begin
                // compare: a.mag*b.den against b.mag*a.den
                w_ma = (r_mi == 2'd0) ? r_a_mag : r_b_mag;
                w_mb = (r_mi == 2'd0) ? r_b_den : r_a_den;
            end
        endcase
    end

    assign w_last_mul = ((r_act == ACT_ADD) || (r_act == ACT_SUB)) ? (r_mi == 2'd2)
                                                                    : (r_mi == 2'd1);
    assign w_bneg = (r_act == ACT_SUB) ? !r_b_neg : r_b_neg;
    assign w_fits = (r_neg ? (r_x <= LIM) : (r_x < LIM)) && (r_y < LIM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            // a finished result moves out, or a taken one leaves
            if (r_state == S_DONE && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_act    <= w_act;
                        r_rnum   <= '0;
                        r_rden   <= '0;
                        r_ord    <= ORD_EQ;
                        r_st     <= ST_OK;
                        r_bn_mag <= op_mag(i_b_num);
                        r_bd_mag <= op_mag(i_b_den);
                        r_b_sgn  <= op_neg(i_b_num) ^ op_neg(i_b_den);
                        r_x      <= {32'd0, op_mag(i_a_num)};
                        r_y      <= {32'd0, op_mag(i_a_den)};
                        r_neg    <= op_neg(i_a_num) ^ op_neg(i_a_den);
                        r_phase  <= PH_A;
                        // zero denominator wins over division by zero
                        if (op_zero(i_a_den) || (w_act != ACT_NORM && op_zero(i_b_den))) begin
                            r_st    <= ST_ZDEN;
                            r_state <= S_DONE;
                        end else if (w_act == ACT_DIV && op_zero(i_b_num)) begin
                            r_st    <= ST_DIVZ;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_GCD_GO;
                        end
                    end
                end
                S_GCD_GO: begin
                    r_state <= S_GCD_WAIT;
                end
                S_GCD_WAIT: begin
                    if (w_gcd_done) begin
                        r_g     <= w_gcd_g;
                        r_state <= S_DIVX_GO;
                    end
                end
                S_DIVX_GO: begin
                    r_state <= S_DIVX_WT;
                end
                S_DIVX_WT: begin
                    if (w_div_done) begin
                        r_x     <= w_quo;
                        r_state <= S_DIVY_GO;
                    end
                end
                S_DIVY_GO: begin
                    r_state <= S_DIVY_WT;
                end
                S_DIVY_WT: begin
                    if (w_div_done) begin
                        r_y     <= w_quo;
                        // a zero numerator carries no sign
                        r_neg   <= r_neg && (r_x != '0);
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    unique case (r_phase)
                        PH_A: begin
                            r_a_mag <= r_x[31:0];
                            r_a_den <= r_y[31:0];
                            r_a_neg <= r_neg;
                            if (r_act == ACT_NORM) begin
                                r_state <= S_CHECK;
                            end else begin
                                r_x     <= {32'd0, r_bn_mag};
                                r_y     <= {32'd0, r_bd_mag};
                                r_neg   <= r_b_sgn;
                                r_phase <= PH_B;
                                r_state <= S_GCD_GO;
                            end
                        end
                        PH_B: begin
                            r_b_mag <= r_x[31:0];
                            r_b_den <= r_y[31:0];
                            r_b_neg <= r_neg;
                            r_mi    <= '0;
                            if (r_act == ACT_ADD || r_act == ACT_SUB) begin
                                // reduce a.den against b.den to get the lcm factors
                                r_x     <= {32'd0, r_a_den};
                                r_neg   <= 1'b0;
                                r_phase <= PH_LCM;
                                r_state <= S_GCD_GO;
                            end else begin
                                r_state <= S_MUL;
                            end
                        end
                        PH_LCM: begin
                            r_mi    <= '0;
                            r_state <= S_MUL;
                        end
                        default: begin
                            r_state <= S_CHECK;
                        end
                    endcase
                end
                S_MUL: begin
                    r_state <= S_MUL_WB;
                end
                S_MUL_WB: begin
                    case (r_mi)
                        2'd0:    r_p0 <= w_prod;
                        2'd1:    r_p1 <= w_prod;
                        default: r_p2 <= w_prod;
                    endcase
                    r_mi <= r_mi + 2'd1;
                    if (!w_last_mul) begin
                        r_state <= S_MUL;
                    end else if (r_act == ACT_ADD || r_act == ACT_SUB) begin
                        r_state <= S_COMB;
                    end else if (r_act == ACT_CMP) begin
                        r_state <= S_CMP;
                    end else begin
                        // multiply and divide: reduce p0 / p1
                        r_x     <= r_p0;
                        r_y     <= w_prod;
                        r_neg   <= r_a_neg ^ r_b_neg;
                        r_phase <= PH_FIN;
                        r_state <= S_GCD_GO;
                    end
                end
                S_COMB: begin
                    // signed sum of the scaled numerators over the lcm
                    r_y     <= r_p0;
                    r_phase <= PH_FIN;
                    r_state <= S_GCD_GO;
                    if (r_a_neg == w_bneg) begin
                        r_x   <= r_p1 + r_p2;
                        r_neg <= r_a_neg;
                    end else if (r_p1 >= r_p2) begin
                        r_x   <= r_p1 - r_p2;
                        r_neg <= r_a_neg;
                    end else begin
                        r_x   <= r_p2 - r_p1;
                        r_neg <= w_bneg;
                    end
                end
                S_CMP: begin
                    // negative operands have nonzero magnitude
                    if (r_a_neg != r_b_neg) begin
                        r_ord <= r_a_neg ? ORD_LT : ORD_GT;
                    end else if (r_p0 == r_p1) begin
                        r_ord <= ORD_EQ;
                    end else if ((r_p0 < r_p1) != r_a_neg) begin
                        r_ord <= ORD_LT;
                    end else begin
                        r_ord <= ORD_GT;
                    end
                    r_state <= S_DONE;
                end
                S_CHECK: begin
                    if (w_fits) begin
                        r_rnum <= r_neg ? -r_x[31:0] : r_x[31:0];
                        r_rden <= r_y[30:0];
                    end else begin
                        r_st <= ST_OVF;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output payload loads when a result moves out of the sequencer
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_onum <= r_rnum;
            r_oden <= r_rden;
            r_oord <= r_ord;
            r_ost  <= r_st;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_ovalid;
    assign o_res_num   = r_onum;
    assign o_res_den   = r_oden;
    assign o_order     = r_oord;
    assign o_status    = r_ost;

    `RAU_ASSERT(a_err_zero, (o_out_valid && o_status != ST_OK) |-> (o_res_num == '0 && o_res_den == '0 && o_order == ORD_EQ), "error result carries data")
    `RAU_ASSERT(a_acc_busy, w_in_acc |=> (r_state != S_IDLE), "accepted request left sequencer idle")
    `RAU_NEVER(a_gcd_nz, (r_state == S_DIVX_GO) && (r_g == '0), "zero gcd fed to divider")

endmodule
